// ----- design/fwst_pkg.sv -----
// Shared types and constants of the four-way SPI to SA lookup table.
`timescale 1ns / 1ps

package fwst_pkg;

   localparam int SETS    = 2048;              // power of two: set numbers wrap by masking
   localparam int WAYS    = 4;
   localparam int SET_W   = $clog2(SETS);
   localparam int WAY_W   = $clog2(WAYS);
   localparam int CNT_W   = $clog2(SETS + 1);
   localparam int TOTAL_W = 14;
   localparam int CAND_W  = 11;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(SETS * WAYS);

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DISABLED = 2'd1;
   localparam logic [1:0] STATUS_OWNER    = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   // Key word: valid at bit 55, owner 54..48, match id 47..32, SPI 31..0.
   typedef struct packed {
      logic        valid;
      logic [6:0]  owner;
      logic [15:0] match_tag;
      logic [31:0] spi;
   } key_type;

   typedef struct packed {
      logic             en;
      logic [SET_W-1:0] addr;
      key_type          key;
      logic [31:0]      value;
   } bank_wr_type;

endpackage

// ----- design/fwst_way_bank.sv -----
// One way of the table: key and value memories; one write and one registered key read port.
`timescale 1ns / 1ps

module fwst_way_bank (
   input  logic                      clock,
   input  fwst_pkg::bank_wr_type     wr,
   input  logic [fwst_pkg::SET_W-1:0] rd_addr,
   output fwst_pkg::key_type         rd_key
);
   import fwst_pkg::*;

   key_type     key_mem [SETS];
   logic [31:0] value_mem [SETS];
   key_type     rd_key_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr]   <= wr.key;
         value_mem[wr.addr] <= wr.value;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   assign rd_key = rd_key_ff;

endmodule

// ----- design/four_way_spi_to_sa_table_core.sv -----
// Top level of the four-way SPI to SA lookup table: sequencer, compare unit and way banks.
`timescale 1ns / 1ps

// Four-way set-associative table mapping (SPI, match id, owner) to an SA index.
// Each way lives in its own bank so all four ways are read together, each at its own
// candidate set (a delete reads candidate set 0 in every way). After reset the block
// runs a clearing pass over all 2048 set rows (one set row per cycle) and holds busy
// high throughout; csr writes are still taken. An item is accepted when start is high
// and busy is low. For add and delete the banks are read on the accept edge, the shared
// compare unit resolves hit, free way or owner check in the next cycle and writes back,
// and the result strobe appears in the cycle after that. A flush whose owner check passes
// walks total_entries/4 set rows (at most 2048), one row per cycle through the same
// compare unit, and keeps busy high until the walk ends. rsp_valid is high for exactly one
// cycle per item and the receiver cannot hold it off; the next item may be accepted in the
// cycle the strobe is shown.

module four_way_spi_to_sa_table_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_kind,
   input  logic [6:0]                   req_owner_lf,
   input  logic                         req_owner_ok,
   input  logic [31:0]                  req_spi,
   input  logic [15:0]                  req_match_tag,
   input  logic [31:0]                  req_assoc_idx,
   input  logic                         req_entry_valid,
   input  logic [fwst_pkg::CAND_W-1:0]  req_cand_set0,
   input  logic [fwst_pkg::CAND_W-1:0]  req_cand_set1,
   input  logic [fwst_pkg::CAND_W-1:0]  req_cand_set2,
   input  logic [fwst_pkg::CAND_W-1:0]  req_cand_set3,
   input  logic [1:0]                   req_target_way,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [fwst_pkg::CAND_W-1:0]  rsp_set_index,
   output logic [1:0]                   rsp_way_used,
   output logic                         rsp_duplicate,
   input  logic                         csr_write_en,
   input  logic [fwst_pkg::TOTAL_W-1:0] csr_write_data
);
   import fwst_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   // capacity register
   logic [TOTAL_W-1:0] total_ff, total_in;

   // clearing pass and flush walk
   logic [SET_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [SET_W-1:0] pend_set_ff, pend_set_in;

   // held item
   logic [1:0]       kind_ff, kind_in;
   logic [6:0]       lf_ff, lf_in;
   logic             ok_ff, ok_in;
   logic [31:0]      spi_ff, spi_in;
   logic [15:0]      mid_ff, mid_in;
   logic [31:0]      sa_ff, sa_in;
   logic             vbit_ff, vbit_in;
   logic [SET_W-1:0] cand_ff [WAYS];
   logic [SET_W-1:0] cand_in [WAYS];
   logic [WAY_W-1:0] way_ff, way_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [CAND_W-1:0] rsp_set_ff, rsp_set_in;
   logic [1:0]        rsp_way_ff, rsp_way_in;
   logic              rsp_dup_ff, rsp_dup_in;

   // bank ports
   logic [SET_W-1:0] req_cand [WAYS];
   logic [SET_W-1:0] rd_addr [WAYS];
   key_type          rd_key [WAYS];
   bank_wr_type      wr_port [WAYS];

   // shared compare unit outputs
   logic [WAYS-1:0]  hit;
   logic [WAYS-1:0]  free;
   logic [WAYS-1:0]  owner_eq;
   logic [WAY_W-1:0] hit_way;
   logic [WAY_W-1:0] free_way;
   logic             table_on;
   logic             add_write;
   logic             del_write;

   logic [TOTAL_W-3:0] quarter;
   logic [CNT_W-1:0]   flush_sets;

   assign busy = reset | (state_ff != ST_IDLE);

   // Set numbers wrap modulo SETS: keep the low bits.
   assign req_cand[0] = req_cand_set0[SET_W-1:0];
   assign req_cand[1] = req_cand_set1[SET_W-1:0];
   assign req_cand[2] = req_cand_set2[SET_W-1:0];
   assign req_cand[3] = req_cand_set3[SET_W-1:0];

   // Flush walks total/4 sets, capped at the table depth.
   assign quarter    = total_ff[TOTAL_W-1:2];
   assign flush_sets = (quarter > (TOTAL_W-2)'(SETS)) ? CNT_W'(SETS) : quarter[CNT_W-1:0];
   assign table_on   = (total_ff != '0);

   // Compare the row just read against the held key and owner.
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         owner_eq[w] = (rd_key[w].owner == lf_ff);
         hit[w]  = rd_key[w].valid && (rd_key[w].spi == spi_ff) &&
                   (rd_key[w].match_tag == mid_ff) && owner_eq[w];
         free[w] = !rd_key[w].valid;
      end
      // lowest way wins
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit[w]) begin
            hit_way = WAY_W'(w);
         end
         if (free[w]) begin
            free_way = WAY_W'(w);
         end
      end
   end

   assign add_write = (state_ff == ST_EXEC) && (kind_ff == KIND_ADD) && table_on && ok_ff &&
                      !(|hit) && (|free);
   assign del_write = (state_ff == ST_EXEC) && (kind_ff == KIND_DELETE) && table_on && ok_ff &&
                      owner_eq[way_ff];

   // Bank read addresses and write ports.
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         if (state_ff == ST_FLUSH) begin
            rd_addr[w] = cnt_ff[SET_W-1:0];
         end else if (req_kind == KIND_DELETE) begin
            rd_addr[w] = req_cand[0];
         end else begin
            rd_addr[w] = req_cand[w];
         end

         wr_port[w] = '0;
         if (state_ff == ST_CLEAR) begin
            wr_port[w].en   = 1'b1;
            wr_port[w].addr = clr_ff;
         end else if (add_write && (free_way == WAY_W'(w))) begin
            wr_port[w].en             = 1'b1;
            wr_port[w].addr           = cand_ff[w];
            wr_port[w].key.valid      = vbit_ff;
            wr_port[w].key.owner      = lf_ff;
            wr_port[w].key.match_tag  = mid_ff;
            wr_port[w].key.spi        = spi_ff;
            wr_port[w].value          = sa_ff;
         end else if (del_write && (way_ff == WAY_W'(w))) begin
            wr_port[w].en   = 1'b1;
            wr_port[w].addr = cand_ff[0];
         end else if ((state_ff == ST_FLUSH) && pend_ff && owner_eq[w]) begin
            // drop every entry of this owner, valid or not
            wr_port[w].en   = 1'b1;
            wr_port[w].addr = pend_set_ff;
         end
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in    = state_ff;
      total_in    = csr_write_en ? csr_write_data : total_ff;
      clr_in      = clr_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      pend_set_in = pend_set_ff;
      kind_in     = kind_ff;
      lf_in       = lf_ff;
      ok_in       = ok_ff;
      spi_in      = spi_ff;
      mid_in      = mid_ff;
      sa_in       = sa_ff;
      vbit_in     = vbit_ff;
      way_in      = way_ff;
      for (int w = 0; w < WAYS; w++) begin
         cand_in[w] = cand_ff[w];
      end
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_set_in    = '0;
      rsp_way_in    = '0;
      rsp_dup_in    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               lf_in    = req_owner_lf;
               ok_in    = req_owner_ok;
               spi_in   = req_spi;
               mid_in   = req_match_tag;
               sa_in    = req_assoc_idx;
               vbit_in  = req_entry_valid;
               way_in   = req_target_way;
               for (int w = 0; w < WAYS; w++) begin
                  cand_in[w] = req_cand[w];
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            case (kind_ff)
               KIND_ADD: begin
                  if (!table_on) begin
                     rsp_status_in = STATUS_DISABLED;
                  end else if (!ok_ff) begin
                     rsp_status_in = STATUS_OWNER;
                  end else if (|hit) begin
                     rsp_dup_in = 1'b1;
                     rsp_set_in = CAND_W'(cand_ff[hit_way]);
                     rsp_way_in = hit_way;
                  end else if (|free) begin
                     rsp_set_in = CAND_W'(cand_ff[free_way]);
                     rsp_way_in = free_way;
                  end else begin
                     rsp_status_in = STATUS_FULL;
                  end
               end
               KIND_DELETE: begin
                  if (!table_on) begin
                     rsp_status_in = STATUS_DISABLED;
                  end else if (!ok_ff || !owner_eq[way_ff]) begin
                     rsp_status_in = STATUS_OWNER;
                  end
               end
               KIND_FLUSH: begin
                  if (flush_sets == '0) begin
                     rsp_status_in = STATUS_OK;
                  end else if (!ok_ff) begin
                     rsp_status_in = STATUS_OWNER;
                  end else begin
                     rsp_valid_in = 1'b0;
                     cnt_in       = '0;
                     state_in     = ST_FLUSH;
                  end
               end
               default: begin
                  rsp_status_in = STATUS_DISABLED;
               end
            endcase
         end
         ST_FLUSH: begin
            // read row cnt while writing back the pending row held in pend_set
            if (cnt_ff == flush_sets) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cnt_in      = cnt_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_set_in = cnt_ff[SET_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         total_ff     <= TOTAL_RESET;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_set_ff   <= pend_set_in;
      kind_ff       <= kind_in;
      lf_ff         <= lf_in;
      ok_ff         <= ok_in;
      spi_ff        <= spi_in;
      mid_ff        <= mid_in;
      sa_ff         <= sa_in;
      vbit_ff       <= vbit_in;
      way_ff        <= way_in;
      for (int w = 0; w < WAYS; w++) begin
         cand_ff[w] <= cand_in[w];
      end
      rsp_status_ff <= rsp_status_in;
      rsp_set_ff    <= rsp_set_in;
      rsp_way_ff    <= rsp_way_in;
      rsp_dup_ff    <= rsp_dup_in;
   end

   for (genvar g = 0; g < WAYS; g++) begin : g_way
      fwst_way_bank u_bank (
         .clock   (clock),
         .wr      (wr_port[g]),
         .rd_addr (rd_addr[g]),
         .rd_key  (rd_key[g])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_set_index = rsp_set_ff;
   assign rsp_way_used  = rsp_way_ff;
   assign rsp_duplicate = rsp_dup_ff;

   // A result only follows the execute cycle or the end of a flush walk.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_FLUSH))
      else $error("result strobe without a finished item");

   // At most one way is written while an add or delete executes.
   a_exec_one_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |->
         $onehot0({wr_port[3].en, wr_port[2].en, wr_port[1].en, wr_port[0].en}))
      else $error("more than one way written by one item");

   // No bank is written while idle.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |->
         !(wr_port[0].en || wr_port[1].en || wr_port[2].en || wr_port[3].en))
      else $error("bank write while idle");

   // The flush walk never overruns its set count.
   a_flush_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (cnt_ff <= flush_sets))
      else $error("flush walk beyond its set count");

   // A duplicate is only reported with an ok status.
   a_dup_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dup_ff) |-> (rsp_status_ff == STATUS_OK))
      else $error("duplicate flagged with an error status");

endmodule
